/* hw/rtl/lrt_pkg.sv */
// Shared types and constants for the log-rank two-group statistic block.
package lrt_pkg;

  localparam int MAX_SUBJECTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_SUBJECTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int TIME_W       = 32;
  localparam int DIV_NUM_W    = 96;
  localparam int DIV_DEN_W    = 64;

  typedef struct packed {
    logic              group_b;
    logic [TIME_W-1:0] time_key;
    logic              event_req;
    logic              last;
  } lrt_in_t;

  typedef struct packed {
    logic signed [31:0] z_stat;
    logic [31:0]        chi_square;
    logic               degenerate;
  } lrt_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic              g;
    logic              e;
  } lrt_entry_t;

endpackage

/* hw/rtl/logrank_two_group_statistic.sv */
// Top level: subject store, merge sort, risk-set walk and final statistic sequencer.
// Subjects load at one per cycle while busy is low; a subject with last set starts the
// computation and busy stays high until the single result strobe. The merge sort runs
// over two ping-pong subject memories, and the walk makes two passes of the shared divider
// per distinct time. The final step runs the square root and two divisions (one division in
// z-only mode; none of them when the variance sum is zero). done is high for exactly one
// cycle with the result on result, and the strobe cannot be stalled.
module logrank_two_group_statistic import lrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lrt_in_t  subject,
  output logic     busy,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output logic     done,
  output lrt_out_t result
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SINIT = 5'd1;
  localparam logic [4:0] ST_SBLK  = 5'd2;
  localparam logic [4:0] ST_MRD   = 5'd3;
  localparam logic [4:0] ST_MCMP  = 5'd4;
  localparam logic [4:0] ST_WST   = 5'd5;
  localparam logic [4:0] ST_WHEAD = 5'd6;
  localparam logic [4:0] ST_WRD   = 5'd7;
  localparam logic [4:0] ST_WCHK  = 5'd8;
  localparam logic [4:0] ST_GM1   = 5'd9;
  localparam logic [4:0] ST_GM2   = 5'd10;
  localparam logic [4:0] ST_GM3   = 5'd11;
  localparam logic [4:0] ST_GM4   = 5'd12;
  localparam logic [4:0] ST_GM5   = 5'd13;
  localparam logic [4:0] ST_GM6   = 5'd14;
  localparam logic [4:0] ST_GM7   = 5'd15;
  localparam logic [4:0] ST_GDE   = 5'd16;
  localparam logic [4:0] ST_GDV   = 5'd17;
  localparam logic [4:0] ST_F0    = 5'd18;
  localparam logic [4:0] ST_FSQ   = 5'd19;
  localparam logic [4:0] ST_FZ    = 5'd20;
  localparam logic [4:0] ST_FM    = 5'd21;
  localparam logic [4:0] ST_FMA   = 5'd22;
  localparam logic [4:0] ST_FCD   = 5'd23;
  localparam logic [4:0] ST_FCW   = 5'd24;

  logic [4:0] state;
  logic       z_only;

  logic [CNT_W-1:0] cnt, na, nb, idx;
  logic [CNT_W-1:0] lo, mid, hi, i_p, j_p, k_p, width;
  logic             src_sel;
  logic [CNT_W-1:0] ra, rb, da, db;
  logic [TIME_W-1:0] t_cur;
  logic [CNT_W-1:0] obs;
  logic [47:0]      esum, vsum, mag;
  logic             neg;
  logic [59:0]      t1, t2, t3, prod;
  logic [95:0]      acc;
  logic [1:0]       kq;
  logic [31:0]      z_r;

  // Subject memories.
  lrt_entry_t mem_a [0:MAX_SUBJECTS-1];
  lrt_entry_t mem_b [0:MAX_SUBJECTS-1];
  lrt_entry_t a0, a1, b0, b1, rd0, rd1, wdata;
  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  logic              we_a, we_b;

  logic             accept, take_j;
  logic [CNT_W-1:0] n, d;
  logic [47:0]      mul_a;
  logic [11:0]      mul_b;
  logic [11:0]      mag_chunk;
  logic [95:0]      prod_sh;
  logic [CNT_W:0]   lo_w, lo_2w, lo_nx, w_dbl;
  logic [47:0]      oq;

  logic              div_start, div_done;
  logic [95:0]       div_num, div_quo;
  logic [63:0]       div_den;
  logic              sq_start, sq_done;
  logic [31:0]       sq_root;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign n      = na + nb;
  assign d      = da + db;
  assign rd0    = src_sel ? b0 : a0;
  assign rd1    = src_sel ? b1 : a1;
  assign take_j = (j_p < hi) && ((i_p >= mid) || (rd1.t < rd0.t));
  assign lo_w   = {1'b0, lo} + {1'b0, width};
  assign lo_2w  = {1'b0, lo} + {width, 1'b0};
  assign lo_nx  = lo_2w;
  assign w_dbl  = {width, 1'b0};
  assign oq     = {5'd0, obs, 32'd0};

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    a0 <= mem_a[raddr0];
    a1 <= mem_a[raddr1];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    b0 <= mem_b[raddr0];
    b1 <= mem_b[raddr1];
  end

  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    case (state)
      ST_MRD: begin
        raddr0 = i_p[ADDR_W-1:0];
        raddr1 = j_p[ADDR_W-1:0];
      end
      ST_WST, ST_WRD: begin
        raddr0 = idx[ADDR_W-1:0];
      end
      default: begin
        raddr0 = '0;
      end
    endcase
  end

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    waddr = k_p[ADDR_W-1:0];
    wdata = take_j ? rd1 : rd0;
    if (accept) begin
      we_a    = (cnt < CNT_W'(MAX_SUBJECTS));
      waddr   = cnt[ADDR_W-1:0];
      wdata.t = subject.time_key;
      wdata.g = subject.group_b;
      wdata.e = subject.event_req;
    end else if (state == ST_MCMP) begin
      we_a = src_sel;
      we_b = !src_sel;
    end
  end

  always_comb begin
    case (kq)
      2'd0:    mag_chunk = mag[11:0];
      2'd1:    mag_chunk = mag[23:12];
      2'd2:    mag_chunk = mag[35:24];
      default: mag_chunk = mag[47:36];
    endcase
    case (kq)
      2'd0:    prod_sh = {36'd0, prod};
      2'd1:    prod_sh = {24'd0, prod, 12'd0};
      2'd2:    prod_sh = {12'd0, prod, 24'd0};
      default: prod_sh = {prod, 36'd0};
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_GM1: begin
        mul_a = 48'(na);
        mul_b = 12'(d);
      end
      ST_GM2: begin
        mul_a = 48'(na);
        mul_b = 12'(nb);
      end
      ST_GM3: begin
        mul_a = prod[47:0];
        mul_b = 12'(d);
      end
      ST_GM4: begin
        mul_a = prod[47:0];
        mul_b = 12'(n - d);
      end
      ST_GM5: begin
        mul_a = 48'(n);
        mul_b = 12'(n);
      end
      ST_GM6: begin
        mul_a = prod[47:0];
        mul_b = 12'(n - CNT_W'(1));
      end
      ST_FM: begin
        mul_a = mag;
        mul_b = mag_chunk;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 60'(mul_a) * 60'(mul_b);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = (state == ST_F0) && (vsum != 48'd0);
    case (state)
      ST_GM7: begin
        div_start = 1'b1;
        div_num   = {4'd0, t1, 32'd0};
        div_den   = 64'(n);
      end
      ST_GDE: begin
        div_start = div_done;
        div_num   = {4'd0, t2, 32'd0};
        div_den   = {4'd0, t3};
      end
      ST_FSQ: begin
        div_start = sq_done;
        div_num   = {40'd0, mag, 8'd0};
        div_den   = {32'd0, sq_root};
      end
      ST_FCD: begin
        div_start = 1'b1;
        div_num   = acc;
        div_den   = {vsum, 16'd0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  lrt_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     ({vsum, 16'd0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      z_only <= 1'b0;
    end else if (cfg_we) begin
      z_only <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      cnt     <= '0;
      na      <= '0;
      nb      <= '0;
      obs     <= '0;
      esum    <= '0;
      vsum    <= '0;
      src_sel <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cnt < CNT_W'(MAX_SUBJECTS)) begin
              cnt <= cnt + CNT_W'(1);
              if (subject.group_b) begin
                nb <= nb + CNT_W'(1);
              end else begin
                na <= na + CNT_W'(1);
              end
            end
            if (subject.last) begin
              state <= ST_SINIT;
            end
          end
        end
        ST_SINIT: begin
          width   <= CNT_W'(1);
          src_sel <= 1'b0;
          lo      <= '0;
          idx     <= '0;
          state   <= (cnt <= CNT_W'(1)) ? ST_WST : ST_SBLK;
        end
        ST_SBLK: begin
          mid   <= (lo_w < {1'b0, cnt}) ? lo_w[CNT_W-1:0] : cnt;
          hi    <= (lo_2w < {1'b0, cnt}) ? lo_2w[CNT_W-1:0] : cnt;
          i_p   <= lo;
          j_p   <= (lo_w < {1'b0, cnt}) ? lo_w[CNT_W-1:0] : cnt;
          k_p   <= lo;
          state <= ST_MRD;
        end
        ST_MRD: begin
          state <= ST_MCMP;
        end
        ST_MCMP: begin
          if (take_j) begin
            j_p <= j_p + CNT_W'(1);
          end else begin
            i_p <= i_p + CNT_W'(1);
          end
          k_p <= k_p + CNT_W'(1);
          if (k_p + CNT_W'(1) == hi) begin
            if (lo_nx >= {1'b0, cnt}) begin
              // End of a pass: the destination becomes the next source.
              src_sel <= !src_sel;
              lo      <= '0;
              if (w_dbl >= {1'b0, cnt}) begin
                idx   <= '0;
                state <= ST_WST;
              end else begin
                width <= w_dbl[CNT_W-1:0];
                state <= ST_SBLK;
              end
            end else begin
              lo    <= lo_nx[CNT_W-1:0];
              state <= ST_SBLK;
            end
          end else begin
            state <= ST_MRD;
          end
        end
        ST_WST: begin
          if (idx == cnt || na == '0 || nb == '0) begin
            state <= ST_F0;
          end else begin
            state <= ST_WHEAD;
          end
        end
        ST_WHEAD: begin
          t_cur <= rd0.t;
          ra    <= CNT_W'(!rd0.g);
          rb    <= CNT_W'(rd0.g);
          da    <= CNT_W'(!rd0.g && rd0.e);
          db    <= CNT_W'(rd0.g && rd0.e);
          idx   <= idx + CNT_W'(1);
          state <= ST_WRD;
        end
        ST_WRD: begin
          state <= (idx == cnt) ? ST_GM1 : ST_WCHK;
        end
        ST_WCHK: begin
          if (rd0.t == t_cur) begin
            if (rd0.g) begin
              rb <= rb + CNT_W'(1);
              db <= db + CNT_W'(rd0.e);
            end else begin
              ra <= ra + CNT_W'(1);
              da <= da + CNT_W'(rd0.e);
            end
            idx   <= idx + CNT_W'(1);
            state <= ST_WRD;
          end else begin
            state <= ST_GM1;
          end
        end
        ST_GM1: state <= ST_GM2;
        ST_GM2: begin
          t1    <= prod;
          state <= ST_GM3;
        end
        ST_GM3: state <= ST_GM4;
        ST_GM4: state <= ST_GM5;
        ST_GM5: begin
          t2    <= prod;
          state <= ST_GM6;
        end
        ST_GM6: state <= ST_GM7;
        ST_GM7: begin
          t3    <= prod;
          state <= ST_GDE;
        end
        ST_GDE: begin
          if (div_done) begin
            esum  <= esum + div_quo[47:0];
            state <= ST_GDV;
          end
        end
        ST_GDV: begin
          if (div_done) begin
            vsum  <= vsum + div_quo[47:0];
            obs   <= obs + da;
            na    <= na - ra;
            nb    <= nb - rb;
            state <= ST_WST;
          end
        end
        ST_F0: begin
          neg <= oq < esum;
          mag <= (oq < esum) ? esum - oq : oq - esum;
          if (vsum == 48'd0) begin
            result.z_stat     <= '0;
            result.chi_square <= '0;
            result.degenerate <= 1'b1;
            done  <= 1'b1;
            cnt   <= '0;
            na    <= '0;
            nb    <= '0;
            obs   <= '0;
            esum  <= '0;
            vsum  <= '0;
            state <= ST_IDLE;
          end else begin
            state <= ST_FSQ;
          end
        end
        ST_FSQ: begin
          if (sq_done) begin
            state <= ST_FZ;
          end
        end
        ST_FZ: begin
          if (div_done) begin
            if (neg) begin
              if ((|div_quo[95:32]) || (div_quo[31:0] > 32'h8000_0000)) begin
                z_r <= 32'h8000_0000;
              end else begin
                z_r <= 32'd0 - div_quo[31:0];
              end
            end else begin
              z_r <= (|div_quo[95:31]) ? 32'h7FFF_FFFF : div_quo[31:0];
            end
            acc   <= '0;
            kq    <= '0;
            state <= z_only ? ST_FCW : ST_FM;
          end
        end
        ST_FM: state <= ST_FMA;
        ST_FMA: begin
          acc <= acc + prod_sh;
          kq  <= kq + 2'd1;
          state <= (kq == 2'd3) ? ST_FCD : ST_FM;
        end
        ST_FCD: state <= ST_FCW;
        ST_FCW: begin
          // In z-only mode this state is entered with the divider idle.
          if (div_done || z_only) begin
            result.z_stat     <= z_r;
            result.chi_square <= z_only ? 32'd0 :
                                 ((|div_quo[95:32]) ? 32'hFFFF_FFFF : div_quo[31:0]);
            result.degenerate <= 1'b0;
            done  <= 1'b1;
            cnt   <= '0;
            na    <= '0;
            nb    <= '0;
            obs   <= '0;
            esum  <= '0;
            vsum  <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SUBJECTS))
    else $error("subject count beyond store depth");
  a_risk_sets: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (na + nb == cnt))
    else $error("risk set counts disagree with stored subjects");
  a_load: assert property (@(posedge clk) disable iff (rst)
    (accept && !subject.last && cnt < CNT_W'(MAX_SUBJECTS)) |=>
      (cnt == $past(cnt) + CNT_W'(1)))
    else $error("accepted subject not stored");

endmodule

/* hw/rtl/lrt_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module lrt_div import lrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 running;
  logic [6:0]           cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (running) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    end
  end

endmodule

/* hw/rtl/lrt_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module lrt_sqrt import lrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        running;
  logic [4:0]  cnt;
  logic [63:0] xs;
  logic [33:0] rem;
  logic [33:0] cur;
  logic [33:0] trial;
  logic        ge;

  assign cur   = {rem[31:0], xs[63:62]};
  assign trial = {root, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      xs   <= {xs[61:0], 2'b00};
      rem  <= ge ? cur - trial : cur;
      root <= {root[30:0], ge};
    end
  end

endmodule

/* verif/logrank_two_group_statistic_tb.sv */
// Self-checking testbench for the log-rank two-group statistic block.
module logrank_two_group_statistic_tb;
  import lrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 600000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  lrt_in_t  subject = '0;
  logic     busy;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     done;
  lrt_out_t result;

  logrank_two_group_statistic u_top (
    .clk(clk), .rst(rst), .start(start), .subject(subject), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block state.
  logic [31:0] subj_time [MAX_SUBJECTS];
  logic        subj_grp  [MAX_SUBJECTS];
  logic        subj_evt  [MAX_SUBJECTS];
  int          subj_count = 0;
  logic        z_only = 1'b0;
  lrt_out_t    stat_queue [$];
  int          idle_pct = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  function automatic logic [63:0] scaled_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, num} << 32) / {64'd0, den};
    return q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic lrt_out_t logrank_stat();
    lrt_out_t    r;
    logic [31:0] tk [$];
    logic        gk [$];
    logic        ek [$];
    logic [31:0] tt;
    logic        tg, te;
    logic [63:0] na, nb, n, da, db, ra, rb, d, obs, expv, vr, oq, mag, s, zm;
    logic [127:0] chi;
    logic        neg;
    int          i, j;
    for (i = 0; i < subj_count; i++) begin
      tk.push_back(subj_time[i]); gk.push_back(subj_grp[i]); ek.push_back(subj_evt[i]);
    end
    // Insertion sort by time; order within a tie does not affect the sums.
    for (i = 1; i < subj_count; i++) begin
      tt = tk[i]; tg = gk[i]; te = ek[i];
      j = i - 1;
      while (j >= 0 && tk[j] > tt) begin
        tk[j+1] = tk[j]; gk[j+1] = gk[j]; ek[j+1] = ek[j];
        j--;
      end
      tk[j+1] = tt; gk[j+1] = tg; ek[j+1] = te;
    end
    na = 0; nb = 0; obs = 0; expv = 0; vr = 0;
    for (i = 0; i < subj_count; i++) if (gk[i]) nb++; else na++;
    n = na + nb;
    i = 0;
    while (i < subj_count && na > 0 && nb > 0) begin
      tt = tk[i]; da = 0; db = 0; ra = 0; rb = 0;
      while (i < subj_count && tk[i] == tt) begin
        if (gk[i]) begin rb++; db += ek[i]; end
        else begin ra++; da += ek[i]; end
        i++;
      end
      d = da + db;
      expv += scaled_div(na * d, n);
      obs += da;
      vr += scaled_div(na * nb * d * (n - d), n * n * (n - 1));
      na -= ra; nb -= rb; n = na + nb;
    end
    r = '0;
    if (vr == 0) begin
      r.degenerate = 1'b1;
    end else begin
      oq = obs << 32;
      neg = oq < expv;
      mag = neg ? expv - oq : oq - expv;
      s = int_sqrt(vr << 16);
      zm = (mag << 8) / s;
      if (neg) begin
        if (zm > 64'h8000_0000) zm = 64'h8000_0000;
        r.z_stat = 32'd0 - zm[31:0];
      end else begin
        if (zm > 64'h7FFF_FFFF) zm = 64'h7FFF_FFFF;
        r.z_stat = zm[31:0];
      end
      if (!z_only) begin
        chi = ({64'd0, mag} * {64'd0, mag}) / {64'd0, vr << 16};
        r.chi_square = (chi > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : chi[31:0];
      end
    end
    return r;
  endfunction

  // Called once per accepted transfer.
  task automatic absorb_subject(lrt_in_t it);
    if (subj_count < MAX_SUBJECTS) begin
      subj_time[subj_count] = it.time_key;
      subj_grp[subj_count]  = it.group_b;
      subj_evt[subj_count]  = it.event_req;
      subj_count++;
    end
    if (it.last) begin
      stat_queue.push_back(logrank_stat());
      subj_count = 0;
    end
  endtask

  task automatic send_subject(lrt_in_t it);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    subject <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_subject(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (stat_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    z_only = v;
    cfg_we <= 1'b0;
  endtask

  task automatic send_one(logic g, logic [31:0] t, logic e, logic l);
    lrt_in_t it;
    it.group_b = g; it.time_key = t; it.event_req = e; it.last = l;
    send_subject(it);
  endtask

  // Sends a whole data set with random content; narrow times give many ties.
  task automatic send_random_set(int n, bit narrow);
    logic [31:0] t;
    for (int k = 0; k < n; k++) begin
      t = narrow ? $urandom_range(7) : $urandom;
      send_one($urandom_range(1), t, $urandom_range(3) != 0, k == n - 1);
    end
  endtask

  task automatic test_degenerate();
    send_one(1'b0, 32'd5, 1'b1, 1'b1);            // lone subject
    send_one(1'b0, 32'd1, 1'b1, 1'b0);            // empty group B
    send_one(1'b0, 32'd2, 1'b1, 1'b1);
    send_one(1'b0, 32'd1, 1'b0, 1'b0);            // no events at all
    send_one(1'b1, 32'd1, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_basic();
    send_one(1'b0, 32'd1, 1'b1, 1'b0);            // A dies first: positive z
    send_one(1'b1, 32'd2, 1'b1, 1'b0);
    send_one(1'b1, 32'd3, 1'b0, 1'b1);
    send_one(1'b1, 32'd1, 1'b1, 1'b0);            // B dies first: negative z
    send_one(1'b0, 32'd2, 1'b1, 1'b0);
    send_one(1'b0, 32'd3, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_ties_extremes();
    send_one(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_one(1'b1, 32'h0000_0000, 1'b1, 1'b0);
    send_one(1'b0, 32'h0000_0000, 1'b1, 1'b0);
    send_one(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_one(1'b0, 32'h8000_0000, 1'b0, 1'b0);
    send_one(1'b1, 32'h8000_0000, 1'b1, 1'b0);
    send_one(1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_z_only();
    write_mode(1'b1);
    send_one(1'b0, 32'd1, 1'b1, 1'b0);
    send_one(1'b1, 32'd4, 1'b1, 1'b0);
    send_one(1'b0, 32'd4, 1'b0, 1'b0);
    send_one(1'b1, 32'd9, 1'b1, 1'b1);
    drain();
    write_mode(1'b0);
  endtask

  // The store fills, and the closing subject is itself dropped.
  task automatic test_store_full();
    for (int k = 0; k < MAX_SUBJECTS + 6; k++)
      send_one($urandom_range(1), $urandom_range(3), $urandom_range(1),
               k == MAX_SUBJECTS + 5);
    drain();
  endtask

  task automatic test_random();
    int sent, n, ph;
    int pcts [4] = '{0, 67, 0, 15};
    sent = 0; ph = 0;
    while (sent < 300) begin
      if (sent >= (ph + 1) * 75 && ph < 3) begin
        drain();
        ph++;
        idle_pct = pcts[ph];
        write_mode(ph[0]);
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
      send_random_set(n, $urandom_range(3) != 0);
      sent += n;
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (stat_queue.size() == 0) begin
        $display("%0t: result with none expected: actual %h", $time, result);
        errors++;
      end else begin
        if (result.z_stat !== stat_queue[0].z_stat) begin
          $display("%0t: z_stat expected %h actual %h", $time,
                   stat_queue[0].z_stat, result.z_stat);
          errors++;
        end
        if (result.chi_square !== stat_queue[0].chi_square) begin
          $display("%0t: chi_square expected %h actual %h", $time,
                   stat_queue[0].chi_square, result.chi_square);
          errors++;
        end
        if (result.degenerate !== stat_queue[0].degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   stat_queue[0].degenerate, result.degenerate);
          errors++;
        end
        void'(stat_queue.pop_front());
      end
    end
  end

  // A cycle counts as progress when a transfer or a result happens.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** logrank_two_group_statistic: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_basic();
    test_ties_extremes();
    test_z_only();
    test_store_full();
    test_random();
    if (errors == 0 && stat_queue.size() == 0) begin
      $display("** logrank_two_group_statistic: PASSED **");
    end else begin
      $display("** logrank_two_group_statistic: FAILED **");
    end
    $finish;
  end

endmodule
